// ===== hdl/pfa_pkg.sv =====
// Shared constants, codes and control structs of the page frame allocator.
// Used by pfa_ctrl, pfa_datapath and page_frame_allocator_refcount.
package pfa_pkg;

  localparam int unsigned NUM_PAGES  = 32768;
  localparam int unsigned PAGE_BYTES = 4096;   // power of two
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned REF_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned IDX_W   = $clog2(NUM_PAGES);
  localparam int unsigned DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int unsigned OFF_W   = $clog2(PAGE_BYTES);
  localparam int unsigned S_W     = ADDR_W + 1 - OFF_W;

  localparam logic [63:0] SPAN_BYTES = 64'(NUM_PAGES) * 64'(PAGE_BYTES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [ADDR_W-1:0] RAM_BASE_RST   = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] FIRST_FREE_RST = 32'h8002_0000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC  = 3'd0,
    ACT_FREE   = 3'd1,
    ACT_INCREF = 3'd2,
    ACT_DECREF = 3'd3,
    ACT_GETREF = 3'd4,
    ACT_INIT   = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_OOM       = 3'd1,
    STAT_BAD_ADDR  = 3'd2,
    STAT_UNDERFLOW = 3'd3,
    STAT_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAM_BASE   = 1'b0,
    CFG_FIRST_FREE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic init_p0;
    logic init_rng;
    logic sweep_step;
    logic sweep_push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } dp_sts_t;

endpackage

// ===== hdl/page_frame_allocator_refcount.sv =====
// Top level of the page frame allocator with reference counts.
// Depends on pfa_pkg, pfa_ctrl and pfa_datapath.
//
// After reset the block clears the reference count memory, one page per
// cycle, through all NUM_PAGES (32768) pages; no item is taken during that pass,
// while configuration writes are. Alloc, free, incref, decref and getref
// read the count and stack memories in the transfer cycle; the execute
// state then does the update and loads the result register. The count
// memory's single read-modify-write per item sets this split. Init passes
// INIT_P0 and INIT_RNG, then walks every page in SWEEP, clearing its count
// and stacking allocatable pages, and ends in the execute state. A held result
// stalls the block in its execute state only; the next item is taken in
// the idle state that follows the loading of the result register.
module page_frame_allocator_refcount import pfa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ACTION_W-1:0]  in_action_i,
  input  logic [ADDR_W-1:0]    in_addr_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  out_status_o,
  output logic [ADDR_W-1:0]    out_page_addr_o,
  output logic [REF_W-1:0]     out_ref_count_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_action_i (in_action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfa_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_action_i     (in_action_i),
    .in_addr_i       (in_addr_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_status_o    (out_status_o),
    .out_page_addr_o (out_page_addr_o),
    .out_ref_count_o (out_ref_count_o)
  );

endmodule

// ===== hdl/pfa_datapath.sv =====
// Datapath of the page frame allocator: config registers, free stack and
// reference count memories, address checks and the result register.
// Depends on pfa_pkg; driven by pfa_ctrl.
module pfa_datapath import pfa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ADDR_W-1:0]     cfg_data_i,
  input  logic [ACTION_W-1:0]   in_action_i,
  input  logic [ADDR_W-1:0]     in_addr_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_sts_t               sts_o,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic [ADDR_W-1:0]     out_page_addr_o,
  output logic [REF_W-1:0]      out_ref_count_o
);

  logic [ADDR_W-1:0]     ram_base_q, first_free_q;
  logic [ACTION_W-1:0]   action_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  rng_q, free_ok_q;
  logic [DEPTH_W-1:0]    depth_q, depth_d;
  logic [IDX_W-1:0]      sweep_q;
  logic [ADDR_W:0]       p0_q;
  logic [S_W-1:0]        s_q;
  logic                  off_nz_q;

  logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
  logic [IDX_W-1:0]      stk_mem [NUM_PAGES];
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [IDX_W-1:0]      stk_rd_q;

  logic [STATUS_W-1:0]   out_status_q;
  logic [ADDR_W-1:0]     out_page_q;
  logic [REF_W-1:0]      out_cnt_q;

  // accept-side address checks
  logic [ADDR_W:0]       in_diff;
  logic                  in_rng, in_free_ok;
  logic [IDX_W-1:0]      in_idx;

  assign in_diff    = {1'b0, in_addr_i} - {1'b0, ram_base_q};
  assign in_rng     = !in_diff[ADDR_W] && (64'(in_diff[ADDR_W-1:0]) < SPAN_BYTES);
  assign in_free_ok = in_rng && (in_addr_i[OFF_W-1:0] == '0) && (in_addr_i >= first_free_q);
  assign in_idx     = IDX_W'(64'(in_diff[ADDR_W-1:0]) >> OFF_W);

  // init range setup
  logic [ADDR_W-1:0] init_start;
  logic [ADDR_W:0]   p0_d, pdiff;

  assign init_start = (first_free_q < ram_base_q) ? ram_base_q : first_free_q;
  assign p0_d       = ({1'b0, init_start} + (ADDR_W+1)'(PAGE_BYTES - 1))
                      & ~(ADDR_W+1)'(PAGE_BYTES - 1);
  assign pdiff      = p0_q - {1'b0, ram_base_q};

  logic push_ok;
  assign push_ok = cmd_i.sweep_push && (64'(sweep_q) >= 64'(s_q))
                   && !(off_nz_q && (sweep_q == IDX_W'(NUM_PAGES - 1)));
  assign sts_o.sweep_last = (sweep_q == IDX_W'(NUM_PAGES - 1));

  // execute step
  logic [STATUS_W-1:0]   ex_status;
  logic [ADDR_W-1:0]     ex_page;
  logic [COUNT_BITS-1:0] ex_cnt;
  logic                  ex_cnt_we, ex_push, ex_pop;
  logic [IDX_W-1:0]      ex_cnt_wa;
  logic [COUNT_BITS-1:0] ex_cnt_wd;
  logic                  stk_full;

  assign stk_full = (depth_q >= DEPTH_W'(NUM_PAGES));

  always_comb begin
    ex_status = STAT_OK;
    ex_page   = '0;
    ex_cnt    = '0;
    ex_cnt_we = 1'b0;
    ex_cnt_wa = idx_q;
    ex_cnt_wd = cnt_rd_q;
    ex_push   = 1'b0;
    ex_pop    = 1'b0;
    case (action_q)
      ACT_ALLOC: begin
        if (depth_q == '0) begin
          ex_status = STAT_OOM;
        end else begin
          ex_pop    = 1'b1;
          ex_cnt_we = 1'b1;
          ex_cnt_wa = stk_rd_q;
          ex_cnt_wd = COUNT_BITS'(1);
          ex_cnt    = COUNT_BITS'(1);
          ex_page   = ADDR_W'(64'(ram_base_q) + (64'(stk_rd_q) << OFF_W));
        end
      end
      ACT_FREE: begin
        if (!free_ok_q) begin
          ex_status = STAT_BAD_ADDR;
        end else if (cnt_rd_q == '0) begin
          ex_status = STAT_UNDERFLOW;
        end else begin
          ex_cnt_we = 1'b1;
          ex_cnt_wd = cnt_rd_q - 1'b1;
          ex_cnt    = ex_cnt_wd;
          ex_push   = (ex_cnt_wd == '0);
        end
      end
      ACT_INCREF: begin
        if (!rng_q) begin
          ex_status = STAT_BAD_ADDR;
        end else if (cnt_rd_q == COUNT_MAX) begin
          ex_status = STAT_OVERFLOW;
          ex_cnt    = cnt_rd_q;
        end else begin
          ex_cnt_we = 1'b1;
          ex_cnt_wd = cnt_rd_q + 1'b1;
          ex_cnt    = ex_cnt_wd;
        end
      end
      ACT_DECREF: begin
        if (!rng_q) begin
          ex_status = STAT_BAD_ADDR;
        end else if (cnt_rd_q == '0) begin
          ex_status = STAT_UNDERFLOW;
        end else begin
          ex_cnt_we = 1'b1;
          ex_cnt_wd = cnt_rd_q - 1'b1;
          ex_cnt    = ex_cnt_wd;
        end
      end
      ACT_GETREF: begin
        if (!rng_q) begin
          ex_status = STAT_BAD_ADDR;
        end else begin
          ex_cnt = cnt_rd_q;
        end
      end
      default: begin
      end
    endcase
  end

  // memory port selection
  logic                  cnt_we, stk_we;
  logic [IDX_W-1:0]      cnt_wa, stk_wa, stk_wd, stk_ra;
  logic [COUNT_BITS-1:0] cnt_wd;

  assign stk_ra = IDX_W'(depth_q - 1'b1);
  assign stk_wa = IDX_W'(depth_q);

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = ex_cnt_wa;
    cnt_wd = ex_cnt_wd;
    stk_we = 1'b0;
    stk_wd = idx_q;
    depth_d = depth_q;
    if (cmd_i.init_p0) begin
      depth_d = '0;
    end else if (cmd_i.sweep_step) begin
      cnt_we = 1'b1;
      cnt_wa = sweep_q;
      cnt_wd = '0;
      stk_we = push_ok;
      stk_wd = sweep_q;
      if (push_ok) depth_d = depth_q + 1'b1;
    end else if (cmd_i.exec) begin
      cnt_we = ex_cnt_we;
      stk_we = ex_push && !stk_full;
      if (ex_pop) begin
        depth_d = depth_q - 1'b1;
      end else if (ex_push && !stk_full) begin
        depth_d = depth_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cmd_i.capture) cnt_rd_q <= cnt_mem[in_idx];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (cmd_i.capture) stk_rd_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_base_q   <= RAM_BASE_RST;
      first_free_q <= FIRST_FREE_RST;
      depth_q      <= '0;
      sweep_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RAM_BASE:   ram_base_q   <= cfg_data_i;
          CFG_FIRST_FREE: first_free_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      depth_q <= depth_d;
      if (cmd_i.init_p0) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_q <= sweep_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q  <= in_action_i;
      idx_q     <= in_idx;
      rng_q     <= in_rng;
      free_ok_q <= in_free_ok;
    end
    if (cmd_i.init_p0) p0_q <= p0_d;
    if (cmd_i.init_rng) begin
      s_q      <= S_W'(pdiff >> OFF_W);
      off_nz_q <= |pdiff[OFF_W-1:0];
    end
    if (cmd_i.exec) begin
      out_status_q <= ex_status;
      out_page_q   <= ex_page;
      out_cnt_q    <= REF_W'(ex_cnt);
    end
  end

  assign out_status_o    = out_status_q;
  assign out_page_addr_o = out_page_q;
  assign out_ref_count_o = out_cnt_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(NUM_PAGES))
    else $error("free stack depth beyond page count");

  a_alloc_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && action_q == ACT_ALLOC && depth_q == '0) |=> out_status_o == STAT_OOM)
    else $error("alloc on empty stack not reported");

  a_clear_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sweep_step && !cmd_i.sweep_push) |=> $stable(depth_q))
    else $error("clearing pass changed stack depth");

endmodule

// ===== hdl/pfa_ctrl.sv =====
// Controller of the page frame allocator: one-hot state machine, handshakes
// and command strobes for pfa_datapath.
// Depends on pfa_pkg.
module pfa_ctrl import pfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ACTION_W-1:0] in_action_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  dp_sts_t             sts_i,
  output ctrl_cmd_t           cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_EXEC     = 6'b000100,
    ST_INIT_P0  = 6'b001000,
    ST_INIT_RNG = 6'b010000,
    ST_SWEEP    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cmd_o.capture    = accept;
  assign cmd_o.exec       = (state_q == ST_EXEC) && out_free;
  assign cmd_o.init_p0    = (state_q == ST_INIT_P0);
  assign cmd_o.init_rng   = (state_q == ST_INIT_RNG);
  assign cmd_o.sweep_step = (state_q == ST_CLEAR) || (state_q == ST_SWEEP);
  assign cmd_o.sweep_push = (state_q == ST_SWEEP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = (in_action_i == ACT_INIT) ? ST_INIT_P0 : ST_EXEC;
      end
      ST_INIT_P0:  state_d = ST_INIT_RNG;
      ST_INIT_RNG: state_d = ST_SWEEP;
      ST_SWEEP: begin
        if (sts_i.sweep_last) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_sweep_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && !sts_i.sweep_last) |=> state_q == ST_SWEEP)
    else $error("init sweep left early");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_action_i != ACT_INIT) |=> state_q == ST_EXEC)
    else $error("accepted item not executed");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EXEC))
    else $error("result raised outside execute step");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for page_frame_allocator_refcount.
// Holds its own model of the free stack and the per-page counts, drives random traffic
// under random stalls and checks every result. Depends on pfa_pkg and the RTL only.
module tb_top;
  import pfa_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;
  localparam logic [ADDR_W-1:0]   TOP_PAGE     = 32'h87FF_F000;

  localparam int QUIET_LIMIT       = 150000;
  localparam int PARK_CYCLES       = 400;
  localparam int SETTLE_CYCLES     = 6;
  localparam int HELD_MAX          = 48;
  localparam int NUM_SETTINGS      = 8;
  localparam int ITEMS_PER_SETTING = 155;

  typedef struct packed {
    status_e            status;
    logic [ADDR_W-1:0]  page;
    logic [REF_W-1:0]   refs;
  } outcome_t;

  typedef enum logic [1:0] {ROW_RUN, ROW_TYPED, ROW_SETUP} row_kind_e;

  // a setup row carries ram_base in addr and first_free in page
  typedef struct packed {
    row_kind_e           kind;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   addr;
    logic [ADDR_W-1:0]   page;
    status_e             status;
    logic [REF_W-1:0]    refs;
  } plan_row_t;

  localparam int PLAN_LEN = 27;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_TYPED, ACT_ALLOC,    32'h0000_0000, 32'h0, STAT_OOM,       16'd0},
    '{ROW_TYPED, ACT_GETREF,   32'h8000_0000, 32'h0, STAT_OK,        16'd0},
    '{ROW_TYPED, ACT_GETREF,   32'h0000_0000, 32'h0, STAT_BAD_ADDR,  16'd0},
    '{ROW_TYPED, ACT_INCREF,   32'h8800_0000, 32'h0, STAT_BAD_ADDR,  16'd0},
    '{ROW_TYPED, ACT_DECREF,   32'h8000_1000, 32'h0, STAT_UNDERFLOW, 16'd0},
    '{ROW_TYPED, ACT_FREE,     32'h8002_0000, 32'h0, STAT_UNDERFLOW, 16'd0},
    '{ROW_TYPED, ACT_UNDEF_LO, 32'hFFFF_FFFF, 32'h0, STAT_OK,        16'd0},
    '{ROW_TYPED, ACT_UNDEF_HI, 32'h0000_0000, 32'h0, STAT_OK,        16'd0},
    '{ROW_TYPED, ACT_INIT,     32'hFFFF_FFFF, 32'h0, STAT_OK,        16'd0},
    '{ROW_TYPED, ACT_ALLOC,    32'h0000_0000, TOP_PAGE, STAT_OK,     16'd1},
    '{ROW_TYPED, ACT_FREE,     32'h8007_F001, 32'h0, STAT_BAD_ADDR,  16'd0},
    '{ROW_TYPED, ACT_FREE,     32'h8000_0000, 32'h0, STAT_BAD_ADDR,  16'd0},
    '{ROW_TYPED, ACT_FREE,     32'h8800_0000, 32'h0, STAT_BAD_ADDR,  16'd0},
    '{ROW_TYPED, ACT_INCREF,   32'h87FF_FFFF, 32'h0, STAT_OK,        16'd2},
    '{ROW_TYPED, ACT_FREE,     TOP_PAGE,      32'h0, STAT_OK,        16'd1},
    '{ROW_TYPED, ACT_FREE,     TOP_PAGE,      32'h0, STAT_OK,        16'd0},
    '{ROW_TYPED, ACT_ALLOC,    32'h0000_0000, TOP_PAGE, STAT_OK,     16'd1},
    '{ROW_RUN,   ACT_ALLOC,    32'h0000_0000, 32'h0, STAT_OK,        16'd0},
    '{ROW_TYPED, ACT_GETREF,   32'h8001_FFFF, 32'h0, STAT_OK,        16'd0},
    '{ROW_RUN,   ACT_DECREF,   32'h87FF_E123, 32'h0, STAT_OK,        16'd0},
    '{ROW_TYPED, ACT_DECREF,   32'h87FF_E000, 32'h0, STAT_UNDERFLOW, 16'd0},
    '{ROW_SETUP, ACT_ALLOC,    32'h8000_0000, 32'h0, STAT_OK,        16'd0},
    '{ROW_TYPED, ACT_INIT,     32'h0000_0000, 32'h0, STAT_OK,        16'd0},
    '{ROW_TYPED, ACT_INCREF,   32'h8000_0000, 32'h0, STAT_OK,        16'd1},
    '{ROW_TYPED, ACT_FREE,     32'h8000_0000, 32'h0, STAT_OK,        16'd0},
    '{ROW_TYPED, ACT_ALLOC,    32'h0000_0000, TOP_PAGE, STAT_OK,     16'd1},
    '{ROW_RUN,   ACT_GETREF,   32'h87FF_FFFF, 32'h0, STAT_OK,        16'd0}
  };

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = CFG_RAM_BASE;
  logic [ADDR_W-1:0]    cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [ACTION_W-1:0]  in_action_i     = ACT_ALLOC;
  logic [ADDR_W-1:0]    in_addr_i       = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [STATUS_W-1:0]  out_status_o;
  logic [ADDR_W-1:0]    out_page_addr_o;
  logic [REF_W-1:0]     out_ref_count_o;

  page_frame_allocator_refcount u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_action_i     (in_action_i),
    .in_addr_i       (in_addr_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_status_o    (out_status_o),
    .out_page_addr_o (out_page_addr_o),
    .out_ref_count_o (out_ref_count_o)
  );

  // allocator image kept by the testbench
  logic [IDX_W-1:0]  free_idx  [NUM_PAGES];
  logic [REF_W-1:0]  page_refs [NUM_PAGES];
  int                stack_fill   = 0;
  logic [ADDR_W-1:0] ram_base_q   = RAM_BASE_RST;
  logic [ADDR_W-1:0] first_free_q = FIRST_FREE_RST;

  outcome_t          outcome_q [$];
  logic [ADDR_W-1:0] held [$];

  int src_gap_max  = 13;
  int sink_gap_max = 13;
  bit park_req     = 1'b0;
  int errors       = 0;
  int checked      = 0;
  int typed_rows   = 0;
  int settings     = 0;
  int quiet_cycles = 0;
  int status_seen [5];

  always #1 clk_i = ~clk_i;

  initial begin : reset_seq
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void stack_page(input logic [IDX_W-1:0] pi);
    // drop the push when every slot is taken
    if (stack_fill < NUM_PAGES) begin
      free_idx[stack_fill] = pi;
      stack_fill++;
    end
  endfunction

  function automatic outcome_t apply_page_action(input logic [ACTION_W-1:0] act,
                                                 input logic [ADDR_W-1:0]   adr);
    outcome_t         res;
    logic [63:0]      span_top;
    logic [63:0]      start;
    logic [63:0]      pg;
    logic             in_span;
    logic [IDX_W-1:0] pi;
    int               i;
    res.status = STAT_OK;
    res.page   = '0;
    res.refs   = '0;
    span_top   = 64'(ram_base_q) + SPAN_BYTES;
    in_span    = (adr >= ram_base_q) && (64'(adr) < span_top);
    pi         = IDX_W'((64'(adr) - 64'(ram_base_q)) >> OFF_W);
    case (act)
      ACT_ALLOC: begin
        if (stack_fill == 0) begin
          res.status = STAT_OOM;
        end else begin
          stack_fill--;
          pi            = free_idx[stack_fill];
          page_refs[pi] = REF_W'(1);
          res.refs      = REF_W'(1);
          res.page      = ram_base_q + (ADDR_W'(pi) << OFF_W);
        end
      end
      ACT_FREE: begin
        if (!in_span || adr[OFF_W-1:0] != '0 || adr < first_free_q) begin
          res.status = STAT_BAD_ADDR;
        end else if (page_refs[pi] == '0) begin
          res.status = STAT_UNDERFLOW;
        end else begin
          page_refs[pi]--;
          res.refs = page_refs[pi];
          if (res.refs == '0) stack_page(pi);
        end
      end
      ACT_INCREF, ACT_DECREF, ACT_GETREF: begin
        if (!in_span) begin
          res.status = STAT_BAD_ADDR;
        end else begin
          if (act == ACT_INCREF) begin
            if (page_refs[pi] == COUNT_MAX) res.status = STAT_OVERFLOW;
            else page_refs[pi]++;
          end else if (act == ACT_DECREF) begin
            if (page_refs[pi] == '0) res.status = STAT_UNDERFLOW;
            else page_refs[pi]--;
          end
          res.refs = page_refs[pi];
        end
      end
      ACT_INIT: begin
        for (i = 0; i < NUM_PAGES; i++) page_refs[i] = '0;
        stack_fill = 0;
        start = (first_free_q < ram_base_q) ? 64'(ram_base_q) : 64'(first_free_q);
        pg    = (start + 64'(PAGE_BYTES) - 64'd1) & ~(64'(PAGE_BYTES) - 64'd1);
        while (pg + 64'(PAGE_BYTES) <= span_top) begin
          stack_page(IDX_W'((pg - 64'(ram_base_q)) >> OFF_W));
          pg = pg + 64'(PAGE_BYTES);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void pick_item(output logic [ACTION_W-1:0] act,
                                    output logic [ADDR_W-1:0]   adr);
    int r;
    r   = $urandom_range(0, 99);
    adr = $urandom();
    if (r < 28)      act = ACT_ALLOC;
    else if (r < 52) act = ACT_FREE;
    else if (r < 66) act = ACT_INCREF;
    else if (r < 76) act = ACT_DECREF;
    else if (r < 86) act = ACT_GETREF;
    else if (r < 90) act = ($urandom_range(0, 1) != 0) ? ACT_UNDEF_HI : ACT_UNDEF_LO;
    else             act = ACT_FREE + ACTION_W'($urandom_range(0, 3));
    if (r >= 28 && r < 86) begin
      if (held.size() != 0 && $urandom_range(0, 9) < 8) begin
        adr = held[$urandom_range(0, held.size() - 1)];
        if (act != ACT_FREE && $urandom_range(0, 2) == 0) adr[OFF_W-1:0] = OFF_W'($urandom());
      end else begin
        case ($urandom_range(0, 4))
          0: adr = ram_base_q - ADDR_W'(1);
          1: adr = ADDR_W'(64'(ram_base_q) + SPAN_BYTES);
          2: adr = first_free_q;
          3: adr = first_free_q - ADDR_W'(PAGE_BYTES) + ADDR_W'($urandom_range(0, 1));
          default: adr = ram_base_q + (ADDR_W'($urandom_range(0, NUM_PAGES - 1)) << OFF_W);
        endcase
      end
    end
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] adr,
                           input bit typed, input outcome_t want);
    int       gap;
    int       n;
    outcome_t got;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_action_i <= act;
    in_addr_i   <= adr;
    do @(posedge clk_i); while (in_stall_o);
    got = apply_page_action(act, adr);
    outcome_q.push_back(typed ? want : got);
    if (typed) typed_rows++;
    // track live pages so that later frees and count actions hit them
    if (act == ACT_INIT) begin
      held.delete();
    end else if (act == ACT_ALLOC && got.status == STAT_OK) begin
      if (held.size() >= HELD_MAX) void'(held.pop_front());
      held.push_back(got.page);
    end else if (act == ACT_FREE && got.status == STAT_OK && got.refs == '0) begin
      for (n = held.size() - 1; n >= 0; n--) if (held[n] == adr) held.delete(n);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] first);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RAM_BASE;
    cfg_data_i <= base;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FIRST_FREE;
    cfg_data_i <= first;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    ram_base_q   = base;
    first_free_q = first;
    settings++;
  endtask

  initial begin : stimulus
    int                  row;
    int                  ph;
    int                  k;
    logic [ACTION_W-1:0] act;
    logic [ADDR_W-1:0]   adr;
    logic [ADDR_W-1:0]   b;
    logic [ADDR_W-1:0]   f;
    outcome_t            want;
    wait (rst_ni);
    @(posedge clk_i);

    for (row = 0; row < PLAN_LEN; row++) begin
      if (plan[row].kind == ROW_SETUP) begin
        drain();
        write_config(plan[row].addr, plan[row].page);
      end else begin
        want.status = plan[row].status;
        want.page   = plan[row].page;
        want.refs   = plan[row].refs;
        send_item(plan[row].action, plan[row].addr, plan[row].kind == ROW_TYPED, want);
      end
    end

    for (ph = 0; ph < NUM_SETTINGS; ph++) begin
      drain();
      case (ph)
        0: begin b = RAM_BASE_RST;  f = FIRST_FREE_RST; end
        1: begin b = 32'h0000_0000; f = 32'h0000_0000; end
        2: begin b = 32'hFFFF_F000; f = 32'hFFFF_FFFF; end
        3: begin b = 32'h1234_5678; f = 32'h1300_0000; end
        4: begin b = 32'h4000_0000; f = 32'h47FF_0000; end
        5: begin
          b = $urandom();
          b[OFF_W-1:0] = '0;
          f = b + ADDR_W'($urandom_range(0, 32'h0800_0000));
        end
        6: begin b = $urandom(); f = $urandom(); end
        default: begin b = 32'hFFFF_FFFF; f = 32'h0000_0000; end
      endcase
      write_config(b, f);
      src_gap_max  = 13;
      sink_gap_max = 13;
      send_item(ACT_INIT, $urandom(), 1'b0, '0);
      for (k = 0; k < ITEMS_PER_SETTING; k++) begin
        if (k % 40 == 0) begin
          src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 13;
          sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
        end
        if (k == 50 && ph % 3 == 0) park_req = 1'b1;
        if (k == 100) drain();
        pick_item(act, adr);
        send_item(act, adr, 1'b0, '0);
      end
    end

    drain();
    $display("tb_top: %0d results checked (%0d against typed values), %0d register settings",
             checked, typed_rows, settings + 1);
    $display("tb_top: ok %0d, out of memory %0d, bad address %0d, underflow %0d, overflow %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : sink_side
    int       stall_left;
    int       park_left;
    outcome_t want;
    stall_left = 0;
    park_left  = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        checked++;
        if (out_status_o <= STAT_OVERFLOW) status_seen[out_status_o]++;
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status %0d page %h refs %0d", $time,
                   out_status_o, out_page_addr_o, out_ref_count_o);
        end else begin
          want = outcome_q.pop_front();
          if (out_status_o !== want.status || out_page_addr_o !== want.page ||
              out_ref_count_o !== want.refs) begin
            errors++;
            $display("%0t: expected status %0d page %h refs %0d, got %0d %h %0d", $time,
                     want.status, want.page, want.refs,
                     out_status_o, out_page_addr_o, out_ref_count_o);
          end
        end
        stall_left = $urandom_range(0, sink_gap_max);
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      if (park_req) begin
        park_req  = 1'b0;
        park_left = PARK_CYCLES;
      end else if (park_left > 0) begin
        park_left--;
      end
      out_stall_i <= (stall_left > 0) || (park_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: tb_top: no transfer for %0d cycles", $time, quiet_cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hdl/pfa_pkg.sv
hdl/pfa_datapath.sv
hdl/pfa_ctrl.sv
hdl/page_frame_allocator_refcount.sv
sim/tb_top.sv
